/* design/sfr_pkg.sv */
// shared types and constants of the scanline filter reconstruction block
package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int ROW_CFG_W = 14;
  localparam int PIX_CFG_W = 3;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_BYTES   = 1'b0,
    CFG_PIXEL_BYTES = 1'b1
  } cfg_reg_t;

  // scanline filter types
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // highest legal filter type byte
  localparam logic [BYTE_W-1:0] FILT_LAST = 8'd4;

  // neighbors and filter handed to the predictor
  typedef struct packed {
    filt_t             filt;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] up;
    logic [BYTE_W-1:0] upleft;
  } pred_req_t;

endpackage

/* design/sfr_ifs.sv */
// valid/ready channel interfaces for the input, result and configuration ports

interface sfr_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] in_byte;
  logic                      image_start;

  modport source (output valid, output in_byte, output image_start, input ready);
  modport sink   (input valid, input in_byte, input image_start, output ready);
endinterface

interface sfr_out_if;
  logic                      valid;
  logic                      ready;
  logic [sfr_pkg::BYTE_W-1:0] out_byte;
  logic                      row_end;
  logic                      bad_filter;

  modport source (output valid, output out_byte, output row_end, output bad_filter,
                  input ready);
  modport sink   (input valid, input out_byte, input row_end, input bad_filter,
                  output ready);
endinterface

interface sfr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sfr_pkg::CFG_IDX_W-1:0] index;
  logic [sfr_pkg::ROW_CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/scanline_filter_reconstruct.sv */
// top level: scanline filter reconstruction with line store
// Takes one stream byte per clock and returns one reconstructed byte per clock at
// full rate while the output is not stalled. The line store is read on the edge
// that accepts a request, prediction and write back follow in the predict stage,
// and the result is then registered in the output register. The previous row
// lives in a line store of MAX_ROW_BYTES bytes with one read and one write per
// cycle and a registered read; a read that hits the entry being written in the
// same cycle is served from a forwarding register, so even one-byte rows run back
// to back. The input stalls only while the output register holds a result that
// is not taken and the predict stage is full.
// Filter bytes and bytes dropped after a bad filter type are taken without a
// result. The line store needs no clearing pass: its read data is only used on rows
// after the first of an image, whose entries the previous row wrote.
module scanline_filter_reconstruct #(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  sfr_in_if.sink            in_ch,
  sfr_out_if.source         out_ch,
  sfr_cfg_if.sink           cfg_ch
);

  localparam int AW   = $clog2(MAX_ROW_BYTES);
  localparam int RB_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int PW   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int BW   = sfr_pkg::BYTE_W;

  // configuration registers
  logic [sfr_pkg::ROW_CFG_W-1:0] row_bytes_r;
  logic [sfr_pkg::PIX_CFG_W-1:0] pix_bytes_r;

  // row control state
  logic          data_r,    data_nxt;
  logic          first_r,   first_nxt;
  logic          aborted_r, aborted_nxt;
  sfr_pkg::filt_t filt_r,   filt_nxt;
  logic [AW-1:0] idx_r,     idx_nxt;

  // predict stage
  logic           p1_valid_r;
  logic           p1_err_r;
  logic [AW-1:0]  p1_idx_r;
  logic           p1_start_r;
  logic           p1_end_r;
  sfr_pkg::filt_t p1_filt_r;
  logic           p1_first_r;
  logic [PW-1:0]  p1_pix_r;
  logic           p1_hit_r;
  logic [BW-1:0]  p1_byte_r;

  // output register
  logic          out_valid_r;
  logic [BW-1:0] out_byte_r;
  logic          out_end_r;
  logic          out_bad_r;

  // line store and forwarding
  logic [BW-1:0] line_mem [MAX_ROW_BYTES];
  logic [BW-1:0] rdata_r;
  logic [BW-1:0] fwd_r;

  // pixel history of the current row
  logic [BW-1:0] left_hist_r [MAX_PIXEL_BYTES];
  logic [BW-1:0] up_hist_r   [MAX_PIXEL_BYTES];

  logic          acc;
  logic          p1_adv;
  logic          p1_wr;
  logic          emit;
  logic          emit_err;
  logic          emit_end;
  logic [AW-1:0] cur_idx;
  logic [RB_W-1:0] rb_eff;
  logic [RB_W-1:0] rb_m1;
  logic [PW-1:0] pix_sel;
  logic          eff_data;
  logic          eff_first;
  logic          eff_aborted;
  logic          rd_hit;
  sfr_pkg::pred_req_t pred_req;
  logic [BW-1:0] pred_val;
  logic [BW-1:0] up_byte;

  // handshakes
  assign p1_adv       = p1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !p1_valid_r || p1_adv;
  assign acc          = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign p1_wr        = p1_adv && !p1_err_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.row_end    = out_end_r;
  assign out_ch.bad_filter = out_bad_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= sfr_pkg::ROW_CFG_W'(1);
      pix_bytes_r <= sfr_pkg::PIX_CFG_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        sfr_pkg::CFG_ROW_BYTES:   row_bytes_r <= cfg_ch.data;
        sfr_pkg::CFG_PIXEL_BYTES: pix_bytes_r <= cfg_ch.data[sfr_pkg::PIX_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row length and pixel distance
  always_comb begin
    if (row_bytes_r == '0) begin
      rb_eff = RB_W'(1);
    end else if (32'(row_bytes_r) > 32'(MAX_ROW_BYTES)) begin
      rb_eff = RB_W'(MAX_ROW_BYTES);
    end else begin
      rb_eff = RB_W'(row_bytes_r);
    end
    rb_m1 = rb_eff - RB_W'(1);
    if (pix_bytes_r == '0) begin
      pix_sel = '0;
    end else if (32'(pix_bytes_r) > 32'(MAX_PIXEL_BYTES)) begin
      pix_sel = PW'(MAX_PIXEL_BYTES - 1);
    end else begin
      pix_sel = PW'(pix_bytes_r - sfr_pkg::PIX_CFG_W'(1));
    end
  end

  // request decode and row control
  always_comb begin
    eff_aborted = in_ch.image_start ? 1'b0 : aborted_r;
    eff_data    = in_ch.image_start ? 1'b0 : data_r;
    eff_first   = in_ch.image_start ? 1'b1 : first_r;
    cur_idx     = (RB_W'(idx_r) >= rb_eff) ? AW'(rb_m1) : idx_r;
    emit_end    = (RB_W'(cur_idx) == rb_m1);
    emit        = 1'b0;
    emit_err    = 1'b0;
    data_nxt    = data_r;
    first_nxt   = first_r;
    aborted_nxt = aborted_r;
    filt_nxt    = filt_r;
    idx_nxt     = idx_r;
    if (acc) begin
      data_nxt    = eff_data;
      first_nxt   = eff_first;
      aborted_nxt = eff_aborted;
      if (!eff_aborted) begin
        if (!eff_data) begin
          if (in_ch.in_byte > sfr_pkg::FILT_LAST) begin
            aborted_nxt = 1'b1;
            emit        = 1'b1;
            emit_err    = 1'b1;
          end else begin
            filt_nxt = sfr_pkg::filt_t'(in_ch.in_byte[2:0]);
            data_nxt = 1'b1;
            idx_nxt  = '0;
          end
        end else begin
          emit = 1'b1;
          if (emit_end) begin
            data_nxt  = 1'b0;
            first_nxt = 1'b0;
          end else begin
            idx_nxt = cur_idx + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r    <= 1'b0;
      first_r   <= 1'b1;
      aborted_r <= 1'b0;
      filt_r    <= sfr_pkg::FILT_NONE;
      idx_r     <= '0;
    end else begin
      data_r    <= data_nxt;
      first_r   <= first_nxt;
      aborted_r <= aborted_nxt;
      filt_r    <= filt_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // read of the entry being written this cycle is forwarded
  assign rd_hit = p1_wr && !emit_err && (p1_idx_r == cur_idx);

  // predict stage load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (acc) begin
      p1_valid_r <= emit;
    end else if (p1_adv) begin
      p1_valid_r <= 1'b0;
    end
  end

  // the first data byte of a row is the only one that finds the position at zero
  always_ff @(posedge clk) begin
    if (acc && emit) begin
      p1_err_r   <= emit_err;
      p1_idx_r   <= cur_idx;
      p1_start_r <= (idx_r == '0);
      p1_end_r   <= emit_end;
      p1_filt_r  <= filt_r;
      p1_first_r <= first_r;
      p1_pix_r   <= pix_sel;
      p1_hit_r   <= rd_hit;
      p1_byte_r  <= in_ch.in_byte;
    end
  end

  // line store: read on data requests, write back from predict stage
  always_ff @(posedge clk) begin
    if (acc && emit && !emit_err) begin
      rdata_r <= line_mem[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (p1_wr) begin
      line_mem[p1_idx_r] <= pred_val;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_wr) begin
      fwd_r <= pred_val;
    end
  end

  // neighbors: left and up-left are zero at the row start, up is zero on the first row
  always_comb begin
    up_byte = p1_first_r ? '0 : (p1_hit_r ? fwd_r : rdata_r);
    pred_req.filt   = p1_filt_r;
    pred_req.up     = up_byte;
    pred_req.left   = p1_start_r ? '0 : left_hist_r[p1_pix_r];
    pred_req.upleft = p1_start_r ? '0 : up_hist_r[p1_pix_r];
  end

  sfr_predict u_predict (
    .req      (pred_req),
    .raw_byte (p1_byte_r),
    .value    (pred_val)
  );

  // pixel history shift, restarted on the first byte of a row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist_r[k] <= '0;
        up_hist_r[k]   <= '0;
      end
    end else if (p1_wr) begin
      left_hist_r[0] <= pred_val;
      up_hist_r[0]   <= up_byte;
      for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
        left_hist_r[k] <= p1_start_r ? '0 : left_hist_r[k-1];
        up_hist_r[k]   <= p1_start_r ? '0 : up_hist_r[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      out_byte_r <= p1_err_r ? '0 : pred_val;
      out_end_r  <= p1_err_r ? 1'b0 : p1_end_r;
      out_bad_r  <= p1_err_r;
    end
  end

  // a forwarded read belongs to a data request
  a_hit_data: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && p1_hit_r) |-> !p1_err_r)
    else $error("forward hit on error request");

  // a bad filter type leaves the image aborted
  a_err_abort: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit_err) |=> aborted_r)
    else $error("bad filter did not abort image");

  // the last byte of a row returns to expecting a filter byte
  a_row_close: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit && !emit_err && emit_end) |=> (!data_r && !first_r))
    else $error("row end did not close row");

  // input stalls only when both stages are full
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (p1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled with room inside");

endmodule

/* design/sfr_predict.sv */
// filter predictor and byte reconstruction (none, sub, up, average, paeth)
module sfr_predict (
  input  sfr_pkg::pred_req_t          req,
  input  logic [sfr_pkg::BYTE_W-1:0]  raw_byte,
  output logic [sfr_pkg::BYTE_W-1:0]  value
);

  logic signed [9:0] d_up;
  logic signed [9:0] d_left;
  logic signed [9:0] d_both;
  logic        [8:0] dist_a;
  logic        [8:0] dist_b;
  logic        [8:0] dist_c;
  logic        [8:0] avg_sum;
  logic [sfr_pkg::BYTE_W-1:0] paeth;
  logic [sfr_pkg::BYTE_W-1:0] pred;

  // paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
  always_comb begin
    d_up   = $signed({2'b00, req.up})   - $signed({2'b00, req.upleft});
    d_left = $signed({2'b00, req.left}) - $signed({2'b00, req.upleft});
    d_both = d_up + d_left;
    dist_a = d_up[9]   ? 9'(-d_up)   : d_up[8:0];
    dist_b = d_left[9] ? 9'(-d_left) : d_left[8:0];
    dist_c = d_both[9] ? 9'(-d_both) : d_both[8:0];
    if (dist_a <= dist_b && dist_a <= dist_c) begin
      paeth = req.left;
    end else if (dist_b <= dist_c) begin
      paeth = req.up;
    end else begin
      paeth = req.upleft;
    end
  end

  // predictor select and modulo-256 add
  always_comb begin
    avg_sum = {1'b0, req.left} + {1'b0, req.up};
    case (req.filt)
      sfr_pkg::FILT_SUB:   pred = req.left;
      sfr_pkg::FILT_UP:    pred = req.up;
      sfr_pkg::FILT_AVG:   pred = avg_sum[8:1];
      sfr_pkg::FILT_PAETH: pred = paeth;
      default:             pred = '0;
    endcase
    value = raw_byte + pred;
  end

endmodule

/* tb/sfr_recon_checker.sv */
// checker: predicts reconstructed scanline bytes and compares them with the result channel
module sfr_recon_checker (
  input  logic clk,
  input  logic rst_n,
  sfr_in_if    in_ch,
  sfr_out_if   out_ch,
  sfr_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   aborts_seen
);

  localparam int MAX_ROW = 8192;
  localparam int MAX_PIX = 4;
  localparam int BW      = sfr_pkg::BYTE_W;

  typedef struct packed {
    logic [BW-1:0] value;
    logic          last;
    logic          bad;
  } recon_t;

  recon_t recon_q[$];

  // shadow of the block's row state
  logic [BW-1:0]                 prev_row [MAX_ROW];
  logic [BW-1:0]                 left_hist [MAX_PIX];
  logic [BW-1:0]                 upleft_hist [MAX_PIX];
  int                            pos;
  sfr_pkg::filt_t                row_filt;
  logic                          first_row;
  logic                          aborted;
  logic [sfr_pkg::ROW_CFG_W-1:0] row_len_cfg;
  logic [sfr_pkg::PIX_CFG_W-1:0] pix_cfg;

  function automatic logic [BW-1:0] paeth_pick(input logic [BW-1:0] a,
                                               input logic [BW-1:0] b,
                                               input logic [BW-1:0] c);
    int p, da, db, dc;
    p  = int'(a) + int'(b) - int'(c);
    da = p - int'(a);
    db = p - int'(b);
    dc = p - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // advance the row state by one stream byte, queue the result it causes
  task automatic reconstruct_byte(input logic [BW-1:0] sbyte, input logic start);
    int rb, bpp, idx, pred;
    logic [BW-1:0] a, up, c, val;
    if (start) begin
      aborted   = 1'b0;
      first_row = 1'b1;
      pos       = 0;
    end else if (aborted) begin
      return;
    end
    // filter type byte
    if (pos == 0) begin
      if (sbyte > sfr_pkg::FILT_LAST) begin
        aborted = 1'b1;
        recon_q.push_back('{value: '0, last: 1'b0, bad: 1'b1});
        return;
      end
      row_filt = sfr_pkg::filt_t'(sbyte[2:0]);
      for (int k = 0; k < MAX_PIX; k++) begin
        left_hist[k]   = '0;
        upleft_hist[k] = '0;
      end
      pos = 1;
      return;
    end
    // effective row length and pixel distance
    rb = int'(row_len_cfg);
    if (rb == 0) rb = 1;
    if (rb > MAX_ROW) rb = MAX_ROW;
    bpp = int'(pix_cfg);
    if (bpp == 0) bpp = 1;
    if (bpp > MAX_PIX) bpp = MAX_PIX;
    idx = pos - 1;
    if (idx >= rb) idx = rb - 1;
    a  = left_hist[bpp-1];
    c  = upleft_hist[bpp-1];
    up = first_row ? '0 : prev_row[idx];
    case (row_filt)
      sfr_pkg::FILT_SUB:   pred = int'(a);
      sfr_pkg::FILT_UP:    pred = int'(up);
      sfr_pkg::FILT_AVG:   pred = (int'(a) + int'(up)) / 2;
      sfr_pkg::FILT_PAETH: pred = int'(paeth_pick(a, up, c));
      default:             pred = 0;
    endcase
    val = sbyte + pred[BW-1:0];
    prev_row[idx] = val;
    for (int k = MAX_PIX - 1; k > 0; k--) begin
      left_hist[k]   = left_hist[k-1];
      upleft_hist[k] = upleft_hist[k-1];
    end
    left_hist[0]   = val;
    upleft_hist[0] = up;
    if (idx + 1 >= rb) begin
      recon_q.push_back('{value: val, last: 1'b1, bad: 1'b0});
      pos       = 0;
      first_row = 1'b0;
    end else begin
      recon_q.push_back('{value: val, last: 1'b0, bad: 1'b0});
      pos = idx + 2;
    end
  endtask

  always @(posedge clk) begin
    recon_t want;
    if (!rst_n) begin
      recon_q.delete();
      for (int k = 0; k < MAX_PIX; k++) begin
        left_hist[k]   = '0;
        upleft_hist[k] = '0;
      end
      pos         = 0;
      row_filt    = sfr_pkg::FILT_NONE;
      first_row   = 1'b1;
      aborted     = 1'b0;
      row_len_cfg = 14'd1;
      pix_cfg     = 3'd1;
      fail_count  = 0;
      checked     = 0;
      aborts_seen = 0;
    end else begin
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          sfr_pkg::CFG_ROW_BYTES:   row_len_cfg = cfg_ch.data;
          sfr_pkg::CFG_PIXEL_BYTES: pix_cfg     = cfg_ch.data[sfr_pkg::PIX_CFG_W-1:0];
          default:                  ;
        endcase
      end
      // compare the result against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (recon_q.size() == 0) begin
          $error("unexpected result: out_byte %02h row_end %0b bad_filter %0b",
                 out_ch.out_byte, out_ch.row_end, out_ch.bad_filter);
          fail_count++;
        end else begin
          want = recon_q.pop_front();
          if (want.bad) aborts_seen++;
          if (out_ch.out_byte !== want.value) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   want.value, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.row_end !== want.last) begin
            $error("row_end mismatch: expected %0b, actual %0b", want.last, out_ch.row_end);
            fail_count++;
          end
          if (out_ch.bad_filter !== want.bad) begin
            $error("bad_filter mismatch: expected %0b, actual %0b",
                   want.bad, out_ch.bad_filter);
            fail_count++;
          end
        end
      end
      // new request on the stream side
      if (in_ch.valid && in_ch.ready) reconstruct_byte(in_ch.in_byte, in_ch.image_start);
    end
    pending = recon_q.size();
  end

endmodule

/* tb/scanline_filter_reconstruct_tb.sv */
// testbench top: stream stimulus, register settings, flow control and verdict
module scanline_filter_reconstruct_tb;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PER_SEG = 455;
  localparam int BW             = sfr_pkg::BYTE_W;
  localparam int RW             = sfr_pkg::ROW_CFG_W;
  localparam int PXW            = sfr_pkg::PIX_CFG_W;

  logic clk;
  logic rst_n;

  sfr_in_if  in_ch();
  sfr_out_if out_ch();
  sfr_cfg_if cfg_ch();

  int fail_count, pending, checked, aborts_seen;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent  = 0;
  int images      = 0;
  int settings    = 0;
  int cycle_count = 0;
  logic [RW-1:0] row_cfg = 14'd1;

  scanline_filter_reconstruct dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sfr_recon_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .aborts_seen (aborts_seen)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("** scanline_filter_reconstruct: FAILED **");
      $finish;
    end
  end

  // one stream request; valid stays high afterwards until the next idle or drain
  task automatic push_byte(input logic [BW-1:0] sbyte, input logic start);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.in_byte     = sbyte;
    in_ch.image_start = start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (start) images++;
  endtask

  // stop the stream and let every outstanding result come back
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write both format registers back to back
  task automatic set_format(input logic [RW-1:0] row_len,
                            input logic [PXW-1:0] pix);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = sfr_pkg::CFG_ROW_BYTES;
    cfg_ch.data  = row_len;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.index = sfr_pkg::CFG_PIXEL_BYTES;
    cfg_ch.data  = RW'(pix);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    row_cfg = row_len;
    settings++;
  endtask

  // one image of random rows; sometimes a bad filter type or an abandoned row
  task automatic send_image();
    int rows, rb, n;
    logic [BW-1:0] fbyte;
    logic cut;
    rows = $urandom_range(1, 5);
    rb = int'(row_cfg);
    if (rb == 0) rb = 1;
    if (rb > 8192) rb = 8192;
    for (int r = 0; r < rows; r++) begin
      if ($urandom_range(0, 19) == 0) begin
        fbyte = BW'($urandom_range(int'(sfr_pkg::FILT_LAST) + 1, 255));
      end else begin
        fbyte = BW'($urandom_range(int'(sfr_pkg::FILT_NONE), int'(sfr_pkg::FILT_LAST)));
      end
      push_byte(fbyte, r == 0);
      if (fbyte > sfr_pkg::FILT_LAST) begin
        // bytes after a bad filter type are dropped until the next image
        repeat ($urandom_range(0, 6)) push_byte(8'($urandom), 1'b0);
        return;
      end
      cut = ($urandom_range(0, 24) == 0);
      n = cut ? $urandom_range(0, rb - 1) : rb;
      repeat (n) push_byte(8'($urandom), 1'b0);
      if (cut) return;
    end
  endtask

  initial begin
    logic [RW-1:0] row_pick;
    int seg_end;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = '0;
    in_ch.image_start = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = sfr_pkg::CFG_ROW_BYTES;
    cfg_ch.data       = '0;
    out_ch.ready      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // one-byte rows at reset format, every filter type, byte extremes
    push_byte(BW'(sfr_pkg::FILT_NONE), 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(BW'(sfr_pkg::FILT_SUB), 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(BW'(sfr_pkg::FILT_UP), 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(BW'(sfr_pkg::FILT_AVG), 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(BW'(sfr_pkg::FILT_PAETH), 1'b0);
    push_byte(8'h01, 1'b0);
    // bad filter types, then dropped bytes
    push_byte(8'hFF, 1'b1);
    push_byte(8'h02, 1'b0);
    push_byte(sfr_pkg::FILT_LAST + 8'd1, 1'b1);
    push_byte(8'hAA, 1'b0);
    wait_idle();

    // multi-byte rows, a new image abandoning a partial row
    set_format(14'd6, 3'd3);
    push_byte(BW'(sfr_pkg::FILT_PAETH), 1'b1);
    for (int k = 0; k < 6; k++) push_byte(8'(k * 51), 1'b0);
    push_byte(BW'(sfr_pkg::FILT_AVG), 1'b0);
    repeat (3) push_byte(8'($urandom), 1'b0);
    push_byte(BW'(sfr_pkg::FILT_SUB), 1'b1);
    repeat (3) push_byte(8'($urandom), 1'b0);
    wait_idle();

    // row length shrunk in the middle of a row ends that row
    set_format(14'd2, 3'd3);
    push_byte(8'h55, 1'b0);
    push_byte(BW'(sfr_pkg::FILT_UP), 1'b0);
    repeat (2) push_byte(8'($urandom), 1'b0);
    wait_idle();

    // zero row length and zero pixel distance act as one
    set_format(14'd0, 3'd0);
    push_byte(BW'(sfr_pkg::FILT_SUB), 1'b1);
    push_byte(8'hC3, 1'b0);
    push_byte(BW'(sfr_pkg::FILT_PAETH), 1'b0);
    push_byte(8'h3C, 1'b0);
    wait_idle();

    // saturated row length and pixel distance: long partial rows, then a new image
    set_format(14'h3FFF, 3'd7);
    push_byte(BW'(sfr_pkg::FILT_PAETH), 1'b1);
    repeat (40) push_byte(8'($urandom), 1'b0);
    push_byte(BW'(sfr_pkg::FILT_AVG), 1'b1);
    repeat (8) push_byte(8'($urandom), 1'b0);
    wait_idle();

    // random images: sender and receiver idling, swapped, then full rate
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          tx_idle_pct = 23;
          rx_idle_pct = 47;
        end
        1: begin
          tx_idle_pct = 47;
          rx_idle_pct = 23;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      seg_end = items_sent + RANDOM_PER_SEG;
      while (items_sent < seg_end) begin
        if (seg_end - items_sent == RANDOM_PER_SEG || $urandom_range(0, 3) == 0) begin
          wait_idle();
          if ($urandom_range(0, 4) == 0) row_pick = RW'($urandom_range(13, 160));
          else row_pick = RW'($urandom_range(0, 12));
          set_format(row_pick, 3'($urandom_range(0, 7)));
        end
        send_image();
      end
    end

    // drain
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("sent %0d stream bytes in %0d images over %0d register settings",
             items_sent, images, settings);
    $display("compared %0d results, %0d of them bad-filter aborts", checked, aborts_seen);
    if (fail_count == 0) begin
      $display("** scanline_filter_reconstruct: PASSED **");
    end else begin
      $display("** scanline_filter_reconstruct: FAILED **");
    end
    $finish;
  end

endmodule

/* scanline_filter_reconstruct.f */
design/sfr_pkg.sv
design/sfr_ifs.sv
design/sfr_predict.sv
design/scanline_filter_reconstruct.sv
tb/sfr_recon_checker.sv
tb/scanline_filter_reconstruct_tb.sv
